// ===== rtl/wwc_pkg.sv =====
// ----------------------------------------------------------------------------
// wwc_pkg
// Shared types and constants of the weighted window curvature block.
// ----------------------------------------------------------------------------
package wwc_pkg;

  localparam int COORD_W     = 20;
  localparam int COL_W       = 12;
  localparam int LEN_W       = 13;
  localparam int MAX_COLUMNS = 4096;
  localparam int V_W         = 26;
  localparam int MAG_W       = 25;
  localparam int CMAG_W      = 20;
  localparam int ASQ_W       = 50;
  localparam int BSQ_W       = 40;
  localparam int SQ_W        = 52;
  localparam int ROOT_W      = 26;
  localparam int REM_W       = 29;
  localparam int B_SHIFT     = 6;
  localparam int B_W         = ROOT_W - B_SHIFT;
  localparam int NUM_W       = 48;
  localparam int DEN_W       = 35;
  localparam int Q_W         = 16;
  localparam int DIV_W       = DEN_W + Q_W;
  localparam int WIN_DEPTH   = 8;
  localparam int CTR_TAP     = 3;

  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = 13'd4000;
  localparam logic [LEN_W-1:0] MAX_LEN          = 13'd4096;
  localparam logic [COL_W-1:0] COL_LAST         = 12'd4095;
  localparam logic [COL_W-1:0] FIRST_RESULT_COL = 12'd9;
  localparam logic [COL_W-1:0] CENTRE_LAG       = 12'd4;
  localparam logic [LEN_W-1:0] TAIL_COLS        = 13'd3;
  localparam logic [NUM_W-1:0] NUM_SCALE        = 48'd4096000;
  localparam logic [DEN_W-1:0] DEN_SCALE        = 35'd20000;
  localparam logic [DEN_W-1:0] DEN_OFFSET       = 35'd1024;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [V_W-1:0]     vsum_t;

  typedef struct packed {
    logic                      occ;
    logic [2:0][COORD_W-1:0]   c;
  } point_t;

  function automatic vsum_t ext(input logic [COORD_W-1:0] a);
    ext = V_W'(signed'(a));
  endfunction

endpackage

// ===== rtl/wwc_in_if.sv =====
// ----------------------------------------------------------------------------
// wwc_in_if
// Point channel: one scan column per transfer.
// ----------------------------------------------------------------------------
interface wwc_in_if;
  logic                        valid;
  logic                        ready;
  logic [wwc_pkg::COORD_W-1:0] pos_x;
  logic [wwc_pkg::COORD_W-1:0] pos_y;
  logic [wwc_pkg::COORD_W-1:0] pos_z;
  logic                        occupied;
  logic                        row_start;

  modport source (output valid, pos_x, pos_y, pos_z, occupied, row_start, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, occupied, row_start, output ready);
endinterface

// ===== rtl/wwc_out_if.sv =====
// ----------------------------------------------------------------------------
// wwc_out_if
// Result channel: one curvature value per transfer.
// ----------------------------------------------------------------------------
interface wwc_out_if;
  logic                      valid;
  logic                      ready;
  logic [wwc_pkg::COL_W-1:0] center_column;
  logic [wwc_pkg::Q_W-1:0]   curvature;
  logic                      saturated;

  modport source (output valid, center_column, curvature, saturated, input ready);
  modport sink   (input valid, center_column, curvature, saturated, output ready);
endinterface

// ===== rtl/wwc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// wwc_cfg_if
// Configuration channel: each transfer writes the row length register.
// ----------------------------------------------------------------------------
interface wwc_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [wwc_pkg::LEN_W-1:0] row_length;

  modport source (output valid, row_length, input ready);
  modport sink   (input valid, row_length, output ready);
endinterface

// ===== rtl/weighted_window_curvature.sv =====
// ----------------------------------------------------------------------------
// weighted_window_curvature
// One point is taken every cycle while the output keeps up; the datapath holds
// a 26-stage square root pipeline and a 16-stage divider.
// A skid register after the pipeline takes one result while the output waits;
// the pipeline and the input stall only while that register is full.
// Synchronous reset empties the window, zeroes the column count, drops all
// items in flight and sets the row length to 4000.
// ----------------------------------------------------------------------------
module weighted_window_curvature (
  input  logic       clk,
  input  logic       rst,
  wwc_in_if.sink     pts,
  wwc_out_if.source  res,
  wwc_cfg_if.sink    cfg
);

  logic en;
  logic accept;

  logic [wwc_pkg::LEN_W-1:0] row_length;
  logic [wwc_pkg::COL_W-1:0] column_count;
  wwc_pkg::point_t           win [wwc_pkg::WIN_DEPTH];

  wwc_pkg::point_t           p;
  logic [wwc_pkg::COL_W-1:0] col;
  logic [wwc_pkg::LEN_W-1:0] len;
  logic                      has_res;
  wwc_pkg::vsum_t            sa [3];
  wwc_pkg::vsum_t            sb [3];

  logic                      s1_v;
  logic [wwc_pkg::COL_W-1:0] s1_col;
  wwc_pkg::vsum_t            s1_sa [3];
  wwc_pkg::vsum_t            s1_sb [3];
  logic [wwc_pkg::COORD_W-1:0] s1_c [3];

  logic                       s2_v;
  logic [wwc_pkg::COL_W-1:0]  s2_col;
  logic [wwc_pkg::MAG_W-1:0]  s2_vm [3];
  logic [wwc_pkg::CMAG_W-1:0] s2_cm [3];

  logic                      s3_v;
  logic [wwc_pkg::COL_W-1:0] s3_col;
  logic [wwc_pkg::ASQ_W-1:0] s3_asq [3];
  logic [wwc_pkg::BSQ_W-1:0] s3_bsq [3];

  logic                       qv    [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::COL_W-1:0]  qcol  [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::SQ_W-1:0]   qrada [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::SQ_W-1:0]   qradb [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::REM_W-1:0]  qrema [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::REM_W-1:0]  qremb [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::ROOT_W-1:0] qrta  [wwc_pkg::ROOT_W+1];
  logic [wwc_pkg::ROOT_W-1:0] qrtb  [wwc_pkg::ROOT_W+1];

  logic                      m_v;
  logic [wwc_pkg::COL_W-1:0] m_col;
  logic [wwc_pkg::NUM_W-1:0] m_num;
  logic [wwc_pkg::DEN_W-1:0] m_den;

  logic                      dv   [wwc_pkg::Q_W+1];
  logic [wwc_pkg::COL_W-1:0] dcol [wwc_pkg::Q_W+1];
  logic                      dsat [wwc_pkg::Q_W+1];
  logic [wwc_pkg::DIV_W-1:0] drem [wwc_pkg::Q_W+1];
  logic [wwc_pkg::DEN_W-1:0] dden [wwc_pkg::Q_W+1];
  logic [wwc_pkg::Q_W-1:0]   dq   [wwc_pkg::Q_W+1];

  logic                      push;
  logic [wwc_pkg::Q_W-1:0]   new_curv;
  logic                      skid_v;
  logic [wwc_pkg::COL_W-1:0] skid_col;
  logic [wwc_pkg::Q_W-1:0]   skid_curv;
  logic                      skid_sat;

  function automatic logic [wwc_pkg::MAG_W-1:0] abs_v(input wwc_pkg::vsum_t v);
    abs_v = v[wwc_pkg::V_W-1] ? wwc_pkg::MAG_W'(-v) : wwc_pkg::MAG_W'(v);
  endfunction

  assign en        = !skid_v;
  assign pts.ready = en;
  assign accept    = pts.valid && en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= wwc_pkg::ROW_LENGTH_RESET;
    end else if (cfg.valid) begin
      row_length <= cfg.row_length;
    end
  end

  // Input stage: window taps, substitution of empty neighbours, partial sums.
  always_comb begin
    p.occ  = pts.occupied;
    p.c[0] = pts.occupied ? pts.pos_x : '0;
    p.c[1] = pts.occupied ? pts.pos_y : '0;
    p.c[2] = pts.occupied ? pts.pos_z : '0;
    col     = pts.row_start ? '0 : column_count;
    len     = (row_length > wwc_pkg::MAX_LEN) ? wwc_pkg::MAX_LEN : row_length;
    has_res = (col >= wwc_pkg::FIRST_RESULT_COL) &&
              ({1'b0, col} + wwc_pkg::TAIL_COLS <= len);
    for (int k = 0; k < 3; k++) begin
      sa[k] = (wwc_pkg::ext(p.occ ? p.c[k] : win[3].c[k]))
            + (wwc_pkg::ext(win[0].occ ? win[0].c[k] : win[3].c[k]) <<< 1)
            + (wwc_pkg::ext(win[1].occ ? win[1].c[k] : win[3].c[k]) <<< 1)
            + (wwc_pkg::ext(win[1].occ ? win[1].c[k] : win[3].c[k]))
            + (wwc_pkg::ext(win[2].occ ? win[2].c[k] : win[3].c[k]) <<< 2);
      sb[k] = (wwc_pkg::ext(win[4].occ ? win[4].c[k] : win[3].c[k]) <<< 2)
            + (wwc_pkg::ext(win[5].occ ? win[5].c[k] : win[3].c[k]) <<< 1)
            + (wwc_pkg::ext(win[5].occ ? win[5].c[k] : win[3].c[k]))
            + (wwc_pkg::ext(win[6].occ ? win[6].c[k] : win[3].c[k]) <<< 1)
            + (wwc_pkg::ext(win[7].occ ? win[7].c[k] : win[3].c[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      for (int j = 0; j < wwc_pkg::WIN_DEPTH; j++) begin
        win[j] <= '0;
      end
    end else if (accept) begin
      column_count <= (col < wwc_pkg::COL_LAST) ? col + 1'b1 : col;
      win[0] <= p;
      for (int j = 1; j < wwc_pkg::WIN_DEPTH; j++) begin
        win[j] <= pts.row_start ? '0 : win[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= accept && has_res;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col <= col - wwc_pkg::CENTRE_LAG;
      s2_col <= s1_col;
      s3_col <= s2_col;
      for (int k = 0; k < 3; k++) begin
        s1_sa[k] <= sa[k];
        s1_sb[k] <= sb[k];
        s1_c[k]  <= win[wwc_pkg::CTR_TAP].c[k];
        s2_vm[k] <= abs_v(s1_sa[k] + s1_sb[k] - (wwc_pkg::ext(s1_c[k]) <<< 4)
                          - (wwc_pkg::ext(s1_c[k]) <<< 2));
        s2_cm[k] <= s1_c[k][wwc_pkg::COORD_W-1] ? wwc_pkg::CMAG_W'(-s1_c[k])
                                                : wwc_pkg::CMAG_W'(s1_c[k]);
        s3_asq[k] <= wwc_pkg::ASQ_W'(s2_vm[k]) * wwc_pkg::ASQ_W'(s2_vm[k]);
        s3_bsq[k] <= wwc_pkg::BSQ_W'(s2_cm[k]) * wwc_pkg::BSQ_W'(s2_cm[k]);
      end
    end
  end

  // Square roots, one result bit per stage; B's radicand is scaled by 2^12.
  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qcol[0]  <= s3_col;
      qrada[0] <= wwc_pkg::SQ_W'(s3_asq[0]) + wwc_pkg::SQ_W'(s3_asq[1])
                + wwc_pkg::SQ_W'(s3_asq[2]);
      qradb[0] <= (wwc_pkg::SQ_W'(s3_bsq[0]) + wwc_pkg::SQ_W'(s3_bsq[1])
                 + wwc_pkg::SQ_W'(s3_bsq[2])) << 12;
      qrema[0] <= '0;
      qremb[0] <= '0;
      qrta[0]  <= '0;
      qrtb[0]  <= '0;
    end
  end

  for (genvar i = 0; i < wwc_pkg::ROOT_W; i++) begin : g_sqrt
    logic [wwc_pkg::REM_W-1:0] sh_a, sh_b, tr_a, tr_b;
    logic                      ge_a, ge_b;

    always_comb begin
      sh_a = {qrema[i][wwc_pkg::REM_W-3:0], qrada[i][wwc_pkg::SQ_W-1 -: 2]};
      sh_b = {qremb[i][wwc_pkg::REM_W-3:0], qradb[i][wwc_pkg::SQ_W-1 -: 2]};
      tr_a = wwc_pkg::REM_W'({qrta[i], 2'b01});
      tr_b = wwc_pkg::REM_W'({qrtb[i], 2'b01});
      ge_a = sh_a >= tr_a;
      ge_b = sh_b >= tr_b;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[i+1] <= 1'b0;
      end else if (en) begin
        qv[i+1] <= qv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qcol[i+1]  <= qcol[i];
        qrada[i+1] <= qrada[i] << 2;
        qradb[i+1] <= qradb[i] << 2;
        qrema[i+1] <= ge_a ? sh_a - tr_a : sh_a;
        qremb[i+1] <= ge_b ? sh_b - tr_b : sh_b;
        qrta[i+1]  <= {qrta[i][wwc_pkg::ROOT_W-2:0], ge_a};
        qrtb[i+1]  <= {qrtb[i][wwc_pkg::ROOT_W-2:0], ge_b};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v   <= 1'b0;
      dv[0] <= 1'b0;
    end else if (en) begin
      m_v   <= qv[wwc_pkg::ROOT_W];
      dv[0] <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_col   <= qcol[wwc_pkg::ROOT_W];
      m_num   <= wwc_pkg::NUM_W'(qrta[wwc_pkg::ROOT_W]) * wwc_pkg::NUM_SCALE;
      m_den   <= wwc_pkg::DEN_W'(qrtb[wwc_pkg::ROOT_W][wwc_pkg::ROOT_W-1:wwc_pkg::B_SHIFT])
               * wwc_pkg::DEN_SCALE + wwc_pkg::DEN_OFFSET;
      dcol[0] <= m_col;
      dsat[0] <= wwc_pkg::DIV_W'(m_num) >= {m_den, wwc_pkg::Q_W'(0)};
      drem[0] <= wwc_pkg::DIV_W'(m_num);
      dden[0] <= m_den;
      dq[0]   <= '0;
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar i = 0; i < wwc_pkg::Q_W; i++) begin : g_div
    logic [wwc_pkg::DIV_W-1:0] dsh;
    logic                      take;

    always_comb begin
      dsh  = wwc_pkg::DIV_W'(dden[i]) << (wwc_pkg::Q_W - 1 - i);
      take = drem[i] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (en) begin
        dv[i+1] <= dv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dcol[i+1] <= dcol[i];
        dsat[i+1] <= dsat[i];
        dden[i+1] <= dden[i];
        drem[i+1] <= take ? drem[i] - dsh : drem[i];
        dq[i+1]   <= {dq[i][wwc_pkg::Q_W-2:0], take};
      end
    end
  end

  assign push     = en && dv[wwc_pkg::Q_W];
  assign new_curv = dsat[wwc_pkg::Q_W] ? '1 : dq[wwc_pkg::Q_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (res.ready) begin
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (res.valid && !res.ready) begin
        skid_v <= 1'b1;
      end else begin
        res.valid <= 1'b1;
      end
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (res.ready) begin
        res.center_column <= skid_col;
        res.curvature     <= skid_curv;
        res.saturated     <= skid_sat;
      end
    end else if (push) begin
      if (res.valid && !res.ready) begin
        skid_col  <= dcol[wwc_pkg::Q_W];
        skid_curv <= new_curv;
        skid_sat  <= dsat[wwc_pkg::Q_W];
      end else begin
        res.center_column <= dcol[wwc_pkg::Q_W];
        res.curvature     <= new_curv;
        res.saturated     <= dsat[wwc_pkg::Q_W];
      end
    end
  end

endmodule

// ===== rtl/wwc_checker.sv =====
// ----------------------------------------------------------------------------
// wwc_checker
// Port-level checks of the weighted window curvature block.
// ----------------------------------------------------------------------------
module wwc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [wwc_pkg::COL_W-1:0] res_col,
  input logic [wwc_pkg::Q_W-1:0]   res_curv,
  input logic                      res_sat
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("Result withdrawn before its transfer.");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_sat |-> res_curv == '1)
    else $error("Saturated result does not hold the maximum curvature.");

  a_col: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_col >= 12'd5)
    else $error("Result given for a centre column below five.");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("Result offered straight after reset.");

endmodule

bind weighted_window_curvature wwc_checker u_wwc_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_col   (res.center_column),
  .res_curv  (res.curvature),
  .res_sat   (res.saturated)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the weighted window curvature block. Scan rows are streamed
// into the point channel and each accepted point is fed to a predictor of the
// nine-point curvature. Predicted results are queued and compared in order
// with every result transfer. Several row lengths and idling phases are used.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [wwc_pkg::COL_W-1:0] col;
    logic [wwc_pkg::Q_W-1:0]   curv;
    logic                      sat;
  } curv_res_t;

  class curv_scoreboard;
    logic signed [wwc_pkg::COORD_W-1:0] wx[8], wy[8], wz[8];
    bit                        wocc[8];
    int unsigned               col_cnt;
    int unsigned               row_len;
    curv_res_t                 pending[$];
    int                        errors;

    function new();
      for (int i = 0; i < 8; i++) begin
        wx[i] = 0; wy[i] = 0; wz[i] = 0; wocc[i] = 0;
      end
      col_cnt = 0;
      row_len = 4000;
      errors = 0;
    endfunction

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 38; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if ((128'(t) * 128'(t)) <= 128'(n)) r = t;
      end
      return r;
    endfunction

    function void note_point(logic [wwc_pkg::COORD_W-1:0] x, logic [wwc_pkg::COORD_W-1:0] y,
                             logic [wwc_pkg::COORD_W-1:0] z, bit occ, bit rs);
      int unsigned c, len;
      longint s[3], cc[3], pv[3], w, nv, nc, a, b, q;
      curv_res_t r;
      pv[0] = occ ? longint'(signed'(x)) : 0;
      pv[1] = occ ? longint'(signed'(y)) : 0;
      pv[2] = occ ? longint'(signed'(z)) : 0;
      if (rs) begin
        c = 0;
        for (int i = 0; i < 8; i++) begin
          wx[i] = 0; wy[i] = 0; wz[i] = 0; wocc[i] = 0;
        end
      end else begin
        c = col_cnt;
      end
      col_cnt = (c < wwc_pkg::MAX_COLUMNS - 1) ? c + 1 : c;
      len = (row_len > wwc_pkg::MAX_COLUMNS) ? wwc_pkg::MAX_COLUMNS : row_len;
      if (c >= 9 && c + 3 <= len) begin
        cc[0] = wx[3]; cc[1] = wy[3]; cc[2] = wz[3];
        nv = 0; nc = 0;
        for (int k = 0; k < 3; k++) begin
          s[k] = (occ ? pv[k] : cc[k]) - 20 * cc[k];
          for (int j = 0; j < 8; j++) begin
            if (j == 3) continue;
            w = (j == 0) ? 2 : (j == 1) ? 3 : (j == 2 || j == 4) ? 4 :
                (j == 5) ? 3 : (j == 6) ? 2 : 1;
            s[k] += w * (wocc[j] ? (k == 0 ? longint'(wx[j]) : k == 1 ?
                    longint'(wy[j]) : longint'(wz[j])) : cc[k]);
          end
          nv += s[k] * s[k];
          nc += cc[k] * cc[k];
        end
        a = isqrt(nv);
        b = isqrt(nc);
        q = (64'd4096000 * a) / (64'd20000 * b + 64'd1024);
        r.col = wwc_pkg::COL_W'(c - 4);
        r.sat = q > 65535;
        r.curv = r.sat ? 16'hFFFF : wwc_pkg::Q_W'(q);
        pending = {pending, r};
      end
      for (int i = 7; i > 0; i--) begin
        wx[i] = wx[i-1]; wy[i] = wy[i-1]; wz[i] = wz[i-1]; wocc[i] = wocc[i-1];
      end
      wx[0] = wwc_pkg::COORD_W'(pv[0]);
      wy[0] = wwc_pkg::COORD_W'(pv[1]);
      wz[0] = wwc_pkg::COORD_W'(pv[2]);
      wocc[0] = occ;
    endfunction

    function void check_result(logic [wwc_pkg::COL_W-1:0] col, logic [wwc_pkg::Q_W-1:0] curv,
                               logic sat);
      curv_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result col %0d curv %0d sat %0b", $time, col, curv, sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (col !== e.col || curv !== e.curv || sat !== e.sat) begin
        $display("%0t: expected col %0d curv %0d sat %0b, actual col %0d curv %0d sat %0b",
                 $time, e.col, e.curv, e.sat, col, curv, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_stall;
  longint cycles;
  curv_scoreboard sb;

  wwc_in_if  pts ();
  wwc_out_if res ();
  wwc_cfg_if cfg ();

  weighted_window_curvature uut (.clk(clk), .rst(rst), .pts(pts), .res(res), .cfg(cfg));

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2000000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) sb.check_result(res.center_column, res.curvature,
                                                        res.saturated);
    if (!rst && pts.valid && pts.ready) sb.note_point(pts.pos_x, pts.pos_y, pts.pos_z,
                                                      pts.occupied, pts.row_start);
  end

  always @(negedge clk) begin
    res.ready <= !($urandom_range(99) < recv_stall);
  end

  // The point stays driven after its transfer until the next call or drain.
  task automatic send_point(logic [wwc_pkg::COORD_W-1:0] x, logic [wwc_pkg::COORD_W-1:0] y,
                            logic [wwc_pkg::COORD_W-1:0] z, bit occ, bit rs);
    while ($urandom_range(99) < send_idle) begin
      pts.valid <= 0;
      @(negedge clk);
    end
    pts.valid <= 1;
    pts.pos_x <= x;
    pts.pos_y <= y;
    pts.pos_z <= z;
    pts.occupied <= occ;
    pts.row_start <= rs;
    @(posedge clk);
    while (!pts.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    pts.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_row_length(logic [wwc_pkg::LEN_W-1:0] v);
    cfg.valid <= 1;
    cfg.row_length <= v;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 0;
    sb.row_len = v;
  endtask

  function automatic logic [wwc_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return wwc_pkg::COORD_W'($urandom_range(0, 200)) - 20'd100;
      default: return wwc_pkg::COORD_W'($urandom());
    endcase
  endfunction

  task automatic send_row(int n, int smooth);
    logic [wwc_pkg::COORD_W-1:0] bx, by, bz;
    bx = rand_coord(); by = rand_coord(); bz = rand_coord();
    for (int i = 0; i < n; i++) begin
      if (smooth != 0)
        send_point(bx + wwc_pkg::COORD_W'(i * 7), by - wwc_pkg::COORD_W'(i * 3), bz,
                   $urandom_range(9) != 0, i == 0);
      else
        send_point(rand_coord(), rand_coord(), rand_coord(), $urandom_range(3) != 0, i == 0);
    end
  endtask

  initial begin
    int lens[4];
    sb = new();
    rst = 1;
    send_idle = 0;
    recv_stall = 0;
    pts.valid = 0; pts.pos_x = 0; pts.pos_y = 0; pts.pos_z = 0;
    pts.occupied = 0; pts.row_start = 0;
    res.ready = 1;
    cfg.valid = 0; cfg.row_length = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extreme centre, some empty points, and an empty centre that saturates.
    write_row_length(13'd16);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: send_point(20'h7FFFF, 20'h80000, 20'h7FFFF, 1, i == 0);
        1: send_point(20'h80000, 20'h7FFFF, 20'h80000, 1, 0);
        2: send_point(20'hFFFFF, 20'h0, 20'h1, i != 6, 0);
        default: send_point(20'h12345, 20'hABCDE, 20'h55555, i < 8, 0);
      endcase
    end
    for (int i = 0; i < 6; i++) send_point(20'h0, 20'h0, 20'h0, i > 2, i == 0);
    drain();

    lens[0] = 13'h1FFF; lens[1] = 11; lens[2] = 12; lens[3] = 40;
    for (int p = 0; p < 4; p++) begin
      write_row_length(wwc_pkg::LEN_W'(lens[p]));
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        default: begin send_idle = 23; recv_stall = 23; end
      endcase
      for (int r = 0; r < 6; r++) send_row($urandom_range(10, 40), $urandom_range(2));
      send_idle = 0;
      recv_stall = 0;
      drain();
    end

    write_row_length(13'd4096);
    send_idle = 23; recv_stall = 23;
    for (int r = 0; r < 8; r++) send_row($urandom_range(16, 60), $urandom_range(2));
    send_idle = 0; recv_stall = 0;
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
